FILE: hdl/four_channel_dma_controller_macros.svh
// ----------------------------------------------------------------------------
// four_channel_dma_controller_macros
// assertion macros shared by the dma controller
// ----------------------------------------------------------------------------
`ifndef FOUR_CHANNEL_DMA_CONTROLLER_MACROS_SVH
`define FOUR_CHANNEL_DMA_CONTROLLER_MACROS_SVH

// concurrent check on rising clock, disabled in reset
`define FDMA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that also holds during reset
`define FDMA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/fdma_pkg.sv
// ----------------------------------------------------------------------------
// fdma_pkg
// types and constants of the four channel dma controller
// ----------------------------------------------------------------------------
`default_nettype none

package fdma_pkg;

   localparam logic [2:0] FUNC_BUS     = 3'd0;
   localparam logic [2:0] FUNC_VBLANK  = 3'd1;
   localparam logic [2:0] FUNC_HBLANK  = 3'd2;
   localparam logic [2:0] FUNC_CAPTURE = 3'd3;
   localparam logic [2:0] FUNC_PROGRAM = 3'd4;

   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   localparam logic [1:0] MODE_INC    = 2'd0;
   localparam logic [1:0] MODE_DEC    = 2'd1;
   localparam logic [1:0] MODE_RELOAD = 2'd3;

   localparam logic [31:0] LOW_LIMIT = 32'h0200_0000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_WRITE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       trig;
      logic [1:0] trig_timing;
      logic       trig_only3;
      logic       load;
      logic       do_read;
      logic       do_write;
      logic       read_skip;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       any_running;
      logic [1:0] sel;
      logic       skip_read;
   } status_type;

endpackage

`default_nettype wire

FILE: hdl/fdma_datapath.sv
// ----------------------------------------------------------------------------
// fdma_datapath
// channel registers, address stepping and bus result generation
// ----------------------------------------------------------------------------
`default_nettype none

module fdma_datapath #(
   parameter int ADDR_WIDTH  = 32,
   parameter int COUNT_WIDTH = 17
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      en,
   input  fdma_pkg::cmd_type        cmd,
   input  wire  [1:0]               cur_ch,
   input  wire  [1:0]               channel,
   input  wire  [31:0]              source_addr,
   input  wire  [31:0]              target_addr,
   input  wire  [15:0]              unit_count,
   input  wire  [10:0]              control,
   input  wire  [31:0]              read_data,
   output fdma_pkg::status_type     status,
   output logic [1:0]               bus_op,
   output logic [31:0]              bus_addr,
   output logic                     bus_word,
   output logic [31:0]              write_data,
   output logic                     idle,
   output logic [3:0]               irq_mask,
   output logic                     cart_irq
);
   import fdma_pkg::*;

   logic [3:0]             run_ff, run_in, ena_ff, ena_in;
   logic [9:0]             mode_ff [4], mode_in [4];
   logic [ADDR_WIDTH-1:0]  src_ff [4], src_in [4], tgt_ff [4], tgt_in [4];
   logic [ADDR_WIDTH-1:0]  btgt_ff [4], btgt_in [4];
   logic [COUNT_WIDTH-1:0] cnt_ff [4], cnt_in [4], bcnt_ff [4], bcnt_in [4];
   logic [31:0]            lat_ff [4], lat_in [4];

   function automatic logic [ADDR_WIDTH-1:0] step(logic [ADDR_WIDTH-1:0] a,
                                                  logic [1:0] m, logic w);
      logic [ADDR_WIDTH-1:0] d;
      d = w ? ADDR_WIDTH'(4) : ADDR_WIDTH'(2);
      if (m == MODE_INC || m == MODE_RELOAD) return a + d;
      else if (m == MODE_DEC) return a - d;
      else return a;
   endfunction

   logic [COUNT_WIDTH-1:0] n;
   logic [31:0] s32, t32, al, d;
   logic [9:0]  sm, wm;
   logic [COUNT_WIDTH-1:0] cdec;

   always_comb begin
      status.any_running = |run_ff;
      priority if (run_ff[0]) status.sel = 2'd0;
      else if (run_ff[1]) status.sel = 2'd1;
      else if (run_ff[2]) status.sel = 2'd2;
      else status.sel = 2'd3;
      sm = mode_ff[status.sel];
      s32 = 32'(src_ff[status.sel]);
      status.skip_read = s32 < LOW_LIMIT;
   end

   always_comb begin
      run_in = run_ff; ena_in = ena_ff;
      mode_in = mode_ff; src_in = src_ff; tgt_in = tgt_ff; btgt_in = btgt_ff;
      cnt_in = cnt_ff; bcnt_in = bcnt_ff; lat_in = lat_ff;
      bus_op = OP_NONE; bus_addr = '0; bus_word = 1'b0; write_data = '0;
      idle = 1'b0; irq_mask = '0; cart_irq = 1'b0;
      n = unit_count == 16'd0 ? COUNT_WIDTH'(17'h10000) : COUNT_WIDTH'(unit_count);
      wm = mode_ff[cur_ch];
      t32 = 32'(tgt_ff[cur_ch]);
      d = read_data;
      cdec = cnt_ff[cur_ch] - COUNT_WIDTH'(1);
      al = '0;
      if (cmd.trig) begin
         for (int c = 0; c < 4; c++)
            if ((!cmd.trig_only3 || c == 3) && ena_ff[c] && mode_ff[c][7:6] == cmd.trig_timing)
               run_in[c] = 1'b1;
      end
      if (cmd.load) begin
         mode_in[channel] = control[9:0];
         ena_in[channel] = control[10];
         src_in[channel] = ADDR_WIDTH'(source_addr);
         tgt_in[channel] = ADDR_WIDTH'(target_addr);
         btgt_in[channel] = ADDR_WIDTH'(target_addr);
         cnt_in[channel] = n;
         bcnt_in[channel] = n;
         run_in[channel] = control[10] && control[7:6] == 2'd0;
      end
      if (cmd.do_read) begin
         if (cmd.read_skip) idle = 1'b1;
         else begin
            bus_op = OP_READ;
            bus_addr = sm[5] ? {s32[31:2], 2'b00} : {s32[31:1], 1'b0};
            bus_word = sm[5];
         end
         if (sm[1:0] != MODE_RELOAD)
            src_in[status.sel] = step(src_ff[status.sel], sm[1:0], sm[5]);
      end
      if (cmd.do_write) begin
         if (!wm[5]) d = {read_data[15:0], read_data[15:0]};
         if (!cmd.read_skip) lat_in[cur_ch] = d;
         if (t32 < LOW_LIMIT) idle = 1'b1;
         else begin
            al = wm[5] ? {t32[31:2], 2'b00} : {t32[31:1], 1'b0};
            bus_op = OP_WRITE;
            bus_addr = al;
            bus_word = wm[5];
            write_data = al[1] ? {16'd0, lat_in[cur_ch][31:16]} : lat_in[cur_ch];
         end
         tgt_in[cur_ch] = step(tgt_ff[cur_ch], wm[3:2], wm[5]);
         cnt_in[cur_ch] = cdec;
         if (cdec == '0) begin
            run_in[cur_ch] = 1'b0;
            if (wm[3:2] == MODE_RELOAD) tgt_in[cur_ch] = btgt_ff[cur_ch];
            if (wm[4]) cnt_in[cur_ch] = bcnt_ff[cur_ch];
            else ena_in[cur_ch] = 1'b0;
            if (wm[8]) irq_mask[cur_ch] = 1'b1;
            if (wm[9] && cur_ch == 2'd3) cart_irq = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0; ena_ff <= '0;
         for (int c = 0; c < 4; c++) begin
            mode_ff[c] <= '0; src_ff[c] <= '0; tgt_ff[c] <= '0; btgt_ff[c] <= '0;
            cnt_ff[c] <= '0; bcnt_ff[c] <= '0; lat_ff[c] <= '0;
         end
      end else if (en) begin
         run_ff <= run_in; ena_ff <= ena_in; mode_ff <= mode_in;
         src_ff <= src_in; tgt_ff <= tgt_in; btgt_ff <= btgt_in;
         cnt_ff <= cnt_in; bcnt_ff <= bcnt_in; lat_ff <= lat_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/fdma_controller.sv
// ----------------------------------------------------------------------------
// fdma_controller
// engine state machine: start, read, write, release
// ----------------------------------------------------------------------------
`default_nettype none

module fdma_controller (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   en,
   input  wire  [2:0]            func,
   input  wire                   bus_locked,
   input  fdma_pkg::status_type  status,
   output fdma_pkg::cmd_type     cmd,
   output logic [1:0]            cur_ch,
   output logic                  busy_next,
   output logic                  idle_ctl
);
   import fdma_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] ch_ff, ch_in;
   logic       skip_ff, skip_in;

   assign cur_ch = ch_ff;

   always_comb begin
      state_in = state_ff; ch_in = ch_ff; skip_in = skip_ff;
      cmd = '0; idle_ctl = 1'b0;
      cmd.read_skip = skip_ff;
      unique case (func)
         FUNC_VBLANK:  begin cmd.trig = 1'b1; cmd.trig_timing = 2'd1; end
         FUNC_HBLANK:  begin cmd.trig = 1'b1; cmd.trig_timing = 2'd2; end
         FUNC_CAPTURE: begin
            cmd.trig = 1'b1; cmd.trig_timing = 2'd3; cmd.trig_only3 = 1'b1;
         end
         FUNC_PROGRAM: cmd.load = 1'b1;
         FUNC_BUS: begin
            unique case (state_ff)
               ST_IDLE: if (!bus_locked && status.any_running) begin
                  state_in = ST_READ; idle_ctl = 1'b1;
               end
               ST_WRITE: begin
                  cmd.do_write = 1'b1; state_in = ST_READ;
               end
               ST_READ: if (status.any_running) begin
                  cmd.do_read = 1'b1; cmd.read_skip = status.skip_read;
                  ch_in = status.sel; skip_in = status.skip_read;
                  state_in = ST_WRITE;
               end else begin
                  idle_ctl = 1'b1; state_in = ST_IDLE; ch_in = 2'd0;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         default: ;
      endcase
      busy_next = state_in != ST_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; ch_ff <= 2'd0; skip_ff <= 1'b0;
      end else if (en) begin
         state_ff <= state_in; ch_ff <= ch_in; skip_ff <= skip_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/four_channel_dma_controller.sv
// ----------------------------------------------------------------------------
// four_channel_dma_controller
// four channel fixed priority dma engine, channel 0 highest
// ----------------------------------------------------------------------------
// req_ carries one item: a bus cycle, a blanking or capture trigger, or a
// channel program. each accepted item yields exactly one rsp_ transfer
// describing the bus cycle (read, write or idle) and interrupt pulses.
// an item is worked in the cycle it is accepted; its result sits in an
// output register the next cycle.
// throughput is one item per cycle, set by the single channel register
// update per item; a new item is taken while a result is held as long as
// the output register is drained in the same cycle.
// when the receiver stalls (rsp_ready low with a result held) req_ready
// drops and the engine holds all state.
// a transfer starts with an idle bus cycle, then alternates read and write,
// and ends with an idle bus cycle handing the bus back.
// reset clears all channels, the engine state and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module four_channel_dma_controller #(
   parameter int ADDR_WIDTH  = 32,
   parameter int COUNT_WIDTH = 17
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [2:0]  req_func,
   input  wire  [1:0]  req_channel,
   input  wire  [31:0] req_source_addr,
   input  wire  [31:0] req_target_addr,
   input  wire  [15:0] req_unit_count,
   input  wire  [10:0] req_control,
   input  wire         req_bus_locked,
   input  wire  [31:0] req_read_data,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [1:0]  rsp_bus_op,
   output logic [31:0] rsp_bus_addr,
   output logic        rsp_bus_word,
   output logic [31:0] rsp_write_data,
   output logic        rsp_idle_cycle,
   output logic        rsp_dma_active,
   output logic [3:0]  rsp_irq_mask,
   output logic        rsp_cart_irq
);
   import fdma_pkg::*;
   `include "four_channel_dma_controller_macros.svh"

   cmd_type    cmd;
   status_type status;
   logic [1:0] cur_ch, op;
   logic       busy_next, idle_ctl, idle_dp, word, cart, en, vld_ff;
   logic [31:0] addr, wdata;
   logic [3:0]  irq;

   assign req_ready = !vld_ff || rsp_ready;
   assign en = req_valid && req_ready;
   assign rsp_valid = vld_ff;

   fdma_controller u_ctl (
      .clock, .reset, .en, .func(req_func), .bus_locked(req_bus_locked),
      .status, .cmd, .cur_ch, .busy_next, .idle_ctl
   );

   fdma_datapath #(.ADDR_WIDTH(ADDR_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
      .clock, .reset, .en, .cmd, .cur_ch, .channel(req_channel),
      .source_addr(req_source_addr), .target_addr(req_target_addr),
      .unit_count(req_unit_count), .control(req_control),
      .read_data(req_read_data), .status, .bus_op(op), .bus_addr(addr),
      .bus_word(word), .write_data(wdata), .idle(idle_dp),
      .irq_mask(irq), .cart_irq(cart)
   );

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (en) vld_ff <= 1'b1;
      else if (rsp_ready) vld_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_bus_op <= op; rsp_bus_addr <= addr; rsp_bus_word <= word;
         rsp_write_data <= wdata; rsp_idle_cycle <= idle_ctl | idle_dp;
         rsp_dma_active <= busy_next; rsp_irq_mask <= irq; rsp_cart_irq <= cart;
      end
   end

   `FDMA_ASSERT(a_hold, clock, reset, (rsp_valid && !rsp_ready) |-> !req_ready, "accepted while result stalled")
   `FDMA_ASSERT(a_irq, clock, reset, rsp_valid && rsp_irq_mask != 4'd0 |-> rsp_bus_op != OP_READ, "interrupt on read cycle")
   `FDMA_ASSERT(a_idle, clock, reset, rsp_valid && rsp_idle_cycle |-> rsp_bus_op == OP_NONE, "idle with bus access")

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the four channel dma controller
// ----------------------------------------------------------------------------
// a table of directed items, then random programs, triggers and bus cycles.
// every response is compared with a local model of the channels and engine,
// or with the typed-in expectation of its directed table row.
`timescale 1ns / 100ps

module testbench;
   import fdma_pkg::*;

   localparam int LIMIT = 400000;

   typedef struct {
      logic [2:0]  func;
      logic [1:0]  chan;
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] cnt;
      logic [10:0] ctl;
      logic        lock;
      logic [31:0] rdata;
   } item_type;

   typedef struct {
      logic [1:0]  op;
      logic [31:0] addr;
      logic        word;
      logic [31:0] wdata;
      logic        idle;
      logic        active;
      logic [3:0]  irq;
      logic        cart;
   } bus_result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [2:0] req_func = 0;
   logic [1:0] req_channel = 0;
   logic [31:0] req_source_addr = 0;
   logic [31:0] req_target_addr = 0;
   logic [15:0] req_unit_count = 0;
   logic [10:0] req_control = 0;
   logic req_bus_locked = 0;
   logic [31:0] req_read_data = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [1:0] rsp_bus_op;
   logic [31:0] rsp_bus_addr;
   logic rsp_bus_word;
   logic [31:0] rsp_write_data;
   logic rsp_idle_cycle;
   logic rsp_dma_active;
   logic [3:0] rsp_irq_mask;
   logic rsp_cart_irq;

   four_channel_dma_controller dut (.*);

   always #10 clock = ~clock;

   // model state
   logic        busy, wpend, skipped;
   logic [1:0]  cur_ch;
   logic        running [4];
   logic        enabled [4];
   logic [9:0]  mode [4];
   logic [31:0] src_ptr [4];
   logic [31:0] dst_ptr [4];
   logic [16:0] remain [4];
   logic [31:0] dst_base [4];
   logic [16:0] cnt_base [4];
   logic [31:0] latch [4];

   bus_result_type expected_bus[$];
   item_type       work[$];
   int errors = 0;
   int cycles = 0;
   bit hold_off = 0;

   function automatic logic [31:0] next_addr(logic [31:0] a, logic [1:0] m, logic w);
      logic [31:0] d;
      d = w ? 32'd4 : 32'd2;
      if (m == MODE_INC || m == MODE_RELOAD) return a + d;
      if (m == MODE_DEC) return a - d;
      return a;
   endfunction

   function automatic void start_timing(logic [1:0] tm, int first);
      for (int c = first; c < 4; c++)
         if (enabled[c] && mode[c][7:6] == tm) running[c] = 1;
   endfunction

   function automatic bus_result_type dma_predict(item_type it);
      bus_result_type r;
      logic [9:0] m;
      logic w;
      logic [31:0] d;
      logic [31:0] a;
      int sel;
      r = '{default: 0};
      case (it.func)
         FUNC_VBLANK: start_timing(2'd1, 0);
         FUNC_HBLANK: start_timing(2'd2, 0);
         FUNC_CAPTURE: start_timing(2'd3, 3);
         FUNC_PROGRAM: begin
            mode[it.chan] = it.ctl[9:0];
            enabled[it.chan] = it.ctl[10];
            src_ptr[it.chan] = it.src;
            dst_ptr[it.chan] = it.dst;
            dst_base[it.chan] = it.dst;
            remain[it.chan] = (it.cnt == 0) ? 17'h10000 : {1'b0, it.cnt};
            cnt_base[it.chan] = remain[it.chan];
            running[it.chan] = it.ctl[10] && it.ctl[7:6] == 0;
         end
         FUNC_BUS: begin
            if (!busy) begin
               if (!it.lock && (running[0] || running[1] || running[2] || running[3])) begin
                  busy = 1;
                  r.idle = 1;
               end
            end else if (wpend) begin
               m = mode[cur_ch];
               w = m[5];
               if (!skipped) begin
                  d = it.rdata;
                  if (!w) d = {d[15:0], d[15:0]};
                  latch[cur_ch] = d;
               end
               a = dst_ptr[cur_ch];
               if (a < LOW_LIMIT) r.idle = 1;
               else begin
                  r.addr = w ? {a[31:2], 2'b00} : {a[31:1], 1'b0};
                  r.op = OP_WRITE;
                  r.word = w;
                  r.wdata = r.addr[1] ? {16'h0, latch[cur_ch][31:16]} : latch[cur_ch];
               end
               dst_ptr[cur_ch] = next_addr(a, m[3:2], w);
               remain[cur_ch] = remain[cur_ch] - 17'd1;
               if (remain[cur_ch] == 0) begin
                  running[cur_ch] = 0;
                  if (m[3:2] == MODE_RELOAD) dst_ptr[cur_ch] = dst_base[cur_ch];
                  if (m[4]) remain[cur_ch] = cnt_base[cur_ch];
                  else enabled[cur_ch] = 0;
                  if (m[8]) r.irq = 4'b1 << cur_ch;
                  if (m[9] && cur_ch == 3) r.cart = 1;
               end
               wpend = 0;
            end else begin
               sel = 4;
               for (int c = 3; c >= 0; c--) if (running[c]) sel = c;
               if (sel < 4) begin
                  m = mode[sel];
                  w = m[5];
                  a = src_ptr[sel];
                  cur_ch = sel[1:0];
                  if (a < LOW_LIMIT) begin
                     r.idle = 1;
                     skipped = 1;
                  end else begin
                     r.addr = w ? {a[31:2], 2'b00} : {a[31:1], 1'b0};
                     r.op = OP_READ;
                     r.word = w;
                     skipped = 0;
                  end
                  if (m[1:0] != MODE_RELOAD) src_ptr[sel] = next_addr(a, m[1:0], w);
                  wpend = 1;
               end else begin
                  r.idle = 1;
                  busy = 0;
                  cur_ch = 0;
               end
            end
         end
         default: ;
      endcase
      r.active = busy;
      return r;
   endfunction

   function automatic item_type bus_item(logic lock, logic [31:0] rd);
      item_type it;
      it = '{default: 0};
      it.func = FUNC_BUS;
      it.lock = lock;
      it.rdata = rd;
      return it;
   endfunction

   function automatic item_type prog_item(logic [1:0] ch, logic [31:0] s, logic [31:0] d,
                                          logic [15:0] n, logic [10:0] ctl);
      item_type it;
      it = '{default: 0};
      it.func = FUNC_PROGRAM;
      it.chan = ch;
      it.src = s;
      it.dst = d;
      it.cnt = n;
      it.ctl = ctl;
      return it;
   endfunction

   function automatic logic [31:0] rand_addr();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 32'h01FF_FFFF);
         1: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
         2: return 32'h0200_0000 + $urandom_range(0, 7);
         default: return $urandom;
      endcase
   endfunction

   function automatic item_type rand_item();
      item_type it;
      it.func = 3'($urandom_range(0, 7));
      it.chan = 2'($urandom);
      it.src = $urandom;
      it.dst = $urandom;
      it.cnt = 16'($urandom);
      it.ctl = 11'($urandom);
      it.lock = ($urandom_range(0, 7) == 0);
      it.rdata = $urandom;
      return it;
   endfunction

   // directed table: expectation typed in where obvious, else predicted
   typedef struct {
      item_type       it;
      bit             typed;
      bus_result_type res;
   } row_type;

   row_type directed[$];

   initial begin
      bus_result_type none;
      none = '{default: 0};
      directed.push_back('{bus_item(0, 32'hFFFF_FFFF), 1, none});
      directed.push_back('{prog_item(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                           11'h7FF), 1, none});
      directed.push_back('{prog_item(2'd0, 32'h0300_0002, 32'h0600_0002, 16'd2,
                           11'h500), 1, none});
      directed.push_back('{bus_item(1, 0), 1, none});
      for (int i = 0; i < 6; i++)
         directed.push_back('{bus_item(0, 32'h1234_0000 + i), 0, none});
      directed.push_back('{prog_item(2'd1, 32'h0000_0010, 32'h0100_0000, 16'd0,
                           11'h63F), 0, none});
      directed.push_back('{prog_item(2'd2, 32'h0800_0000, 32'h0800_0100, 16'd1,
                           11'h78D), 0, none});
      directed.push_back('{rand_item(), 0, none});
      directed[$].it.func = FUNC_VBLANK;
      directed.push_back('{rand_item(), 0, none});
      directed[$].it.func = FUNC_HBLANK;
      directed.push_back('{rand_item(), 0, none});
      directed[$].it.func = FUNC_CAPTURE;
      directed.push_back('{rand_item(), 0, none});
      directed[$].it.func = 3'd7;
      for (int i = 0; i < 8; i++)
         directed.push_back('{bus_item(0, 32'hCAFE_F00D ^ i), 0, none});
   end

   // sender
   initial begin
      item_type it;
      int gap;
      int lim;
      busy = 0; wpend = 0; skipped = 0; cur_ch = 0;
      for (int c = 0; c < 4; c++) begin
         running[c] = 0; enabled[c] = 0; mode[c] = 0; src_ptr[c] = 0;
         dst_ptr[c] = 0; remain[c] = 0; dst_base[c] = 0; cnt_base[c] = 0;
         latch[c] = 0;
      end
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      #0;
      for (int i = 0; i < directed.size(); i++) work.push_back(directed[i].it);
      // random part: mostly programmed channels followed by bus cycles
      while (work.size() < 850) begin
         if ($urandom_range(0, 3) == 0) work.push_back(rand_item());
         else begin
            it = prog_item(2'($urandom), rand_addr(), rand_addr(),
                           16'($urandom_range(1, 5)), 11'($urandom));
            if ($urandom_range(0, 30) == 0) it.cnt = 0;
            it.ctl[10] = ($urandom_range(0, 5) != 0);
            work.push_back(it);
            if ($urandom_range(0, 1)) begin
               it = rand_item();
               it.func = 3'($urandom_range(1, 3));
               work.push_back(it);
            end
            lim = $urandom_range(4, 20);
            for (int k = 0; k < lim; k++)
               work.push_back(bus_item($urandom_range(0, 9) == 0, $urandom));
         end
      end
      for (int i = 0; i < work.size(); i++) begin
         gap = (i > 500 && i < 540) ? 0 :
               ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15));
         if (i % 97 < 30) gap = 0;
         if (i == 300 && gap == 0) gap = 1;
         if (gap != 0) req_valid <= 0;
         if (i == 300) begin
            while (expected_bus.size() != 0) @(posedge clock);
         end
         if (i == 500) hold_off = 1;
         repeat (gap) @(posedge clock);
         it = work[i];
         req_valid <= 1;
         req_func <= it.func;
         req_channel <= it.chan;
         req_source_addr <= it.src;
         req_target_addr <= it.dst;
         req_unit_count <= it.cnt;
         req_control <= it.ctl;
         req_bus_locked <= it.lock;
         req_read_data <= it.rdata;
         do @(posedge clock); while (!req_ready);
         expected_bus.push_back(dma_predict(it));
         if (i < directed.size() && directed[i].typed) begin
            if (expected_bus[$] != directed[i].res) begin
               $display("%0t directed row %0d: table and model disagree", $time, i);
               errors++;
            end
            expected_bus[$] = directed[i].res;
         end
      end
      req_valid <= 0;
      while (expected_bus.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end

   // receiver
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            hold_off = 0;
            rsp_ready <= 0;
            repeat (60) @(posedge clock);
         end
         stall = ($urandom_range(0, 2) == 0 || (cycles / 500) % 3 == 0) ? 0 :
                 $urandom_range(0, 15);
         if (stall != 0) begin
            rsp_ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // checker
   always @(posedge clock) begin
      bus_result_type e;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bus.size() == 0) begin
            $display("%0t unexpected transfer", $time);
            errors = errors + 1;
         end else begin
            e = expected_bus.pop_front();
            if (rsp_bus_op !== e.op || rsp_bus_addr !== e.addr ||
                rsp_bus_word !== e.word || rsp_write_data !== e.wdata ||
                rsp_idle_cycle !== e.idle || rsp_dma_active !== e.active ||
                rsp_irq_mask !== e.irq || rsp_cart_irq !== e.cart) begin
               $display("%0t mismatch expected op %0d addr %h word %b data %h idle %b",
                        $time, e.op, e.addr, e.word, e.wdata, e.idle,
                        " act %b irq %h cart %b", e.active, e.irq, e.cart);
               $display("%0t          actual op %0d addr %h word %b data %h idle %b",
                        $time, rsp_bus_op, rsp_bus_addr, rsp_bus_word, rsp_write_data,
                        rsp_idle_cycle, " act %b irq %h cart %b", rsp_dma_active,
                        rsp_irq_mask, rsp_cart_irq);
               errors = errors + 1;
            end
         end
      end
      if (cycles > LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

endmodule
